// ===== src/mect_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mouse event cursor tracker.
package mect_pkg;

   // Input element op codes
   localparam logic [2:0] OP_X_DELTA = 3'd0;
   localparam logic [2:0] OP_Y_DELTA = 3'd1;
   localparam logic [2:0] OP_LEFT    = 3'd2;
   localparam logic [2:0] OP_RIGHT   = 3'd3;
   localparam logic [2:0] OP_IGNORE  = 3'd4;
   localparam logic [2:0] OP_FLUSH   = 3'd5;

   // Result event codes
   localparam logic [2:0] EV_MOVE         = 3'd0;
   localparam logic [2:0] EV_LEFT_DOWN    = 3'd1;
   localparam logic [2:0] EV_LEFT_DOUBLE  = 3'd2;
   localparam logic [2:0] EV_LEFT_UP      = 3'd3;
   localparam logic [2:0] EV_RIGHT_DOWN   = 3'd4;
   localparam logic [2:0] EV_RIGHT_DOUBLE = 3'd5;
   localparam logic [2:0] EV_RIGHT_UP     = 3'd6;

   // Configuration register indexes
   localparam logic [2:0] CSR_X_SENSITIVITY     = 3'd0;
   localparam logic [2:0] CSR_Y_SENSITIVITY     = 3'd1;
   localparam logic [2:0] CSR_CLIP_LEFT         = 3'd2;
   localparam logic [2:0] CSR_CLIP_RIGHT        = 3'd3;
   localparam logic [2:0] CSR_CLIP_TOP          = 3'd4;
   localparam logic [2:0] CSR_CLIP_BOTTOM       = 3'd5;
   localparam logic [2:0] CSR_CLAMP_ENABLE      = 3'd6;
   localparam logic [2:0] CSR_DOUBLE_CLICK_TIME = 3'd7;

   localparam int CSR_DATA_W = 16;

   // Configuration reset values
   localparam logic [7:0]  RST_SENSITIVITY      = 8'd1;
   localparam logic [12:0] RST_CLIP_FAR         = 13'd4096;
   localparam logic [15:0] RST_DOUBLE_CLICK     = 16'd250;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_X     = 3'd1,
      KIND_Y     = 3'd2,
      KIND_LEFT  = 3'd3,
      KIND_RIGHT = 3'd4
   } kind_type;

   typedef struct packed {
      logic        commit;
      kind_type    kind;
      logic [31:0] value;     // scaled delta, or button state in bit 0
      logic [31:0] time_now;
   } entry_type;

   typedef struct packed {
      logic [7:0]  x_sensitivity;
      logic [7:0]  y_sensitivity;
      logic [11:0] clip_left;
      logic [12:0] clip_right;
      logic [11:0] clip_top;
      logic [12:0] clip_bottom;
      logic        clamp_enable;
      logic [15:0] double_click_time;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/mect_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts elements, tracks sequence groups and scales deltas.
module mect_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_op,
   input  logic signed [15:0]        req_data,
   input  logic [31:0]               req_seq_id,
   input  logic [31:0]               req_time_now,
   input  mect_pkg::cfg_type         cfg,
   input  mect_pkg::queue_status_type q_status,
   output logic                      q_push,
   output mect_pkg::entry_type       q_entry
);

   logic        seq_valid_ff, seq_valid_in;
   logic [31:0] current_seq_ff, current_seq_in;
   logic        accept;
   logic        is_flush;
   logic [7:0]  sens;
   logic signed [24:0] product;
   mect_pkg::kind_type kind;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign is_flush  = (req_op == mect_pkg::OP_FLUSH);

   always_comb begin
      unique case (req_op)
         mect_pkg::OP_X_DELTA: kind = mect_pkg::KIND_X;
         mect_pkg::OP_Y_DELTA: kind = mect_pkg::KIND_Y;
         mect_pkg::OP_LEFT:    kind = mect_pkg::KIND_LEFT;
         mect_pkg::OP_RIGHT:   kind = mect_pkg::KIND_RIGHT;
         default:              kind = mect_pkg::KIND_NONE;
      endcase
   end

   assign sens    = (req_op == mect_pkg::OP_Y_DELTA) ? cfg.y_sensitivity : cfg.x_sensitivity;
   assign product = $signed({1'b0, sens}) * req_data;

   always_comb begin
      q_entry.commit   = is_flush || (seq_valid_ff && (req_seq_id != current_seq_ff));
      q_entry.kind     = kind;
      q_entry.time_now = req_time_now;
      if ((kind == mect_pkg::KIND_LEFT) || (kind == mect_pkg::KIND_RIGHT)) begin
         q_entry.value = {31'd0, (req_data[7:0] != 8'd0)};
      end else begin
         q_entry.value = {{7{product[24]}}, product};
      end
   end

   assign q_push = accept;

   // A flush keeps the open group; any other element opens or continues one
   always_comb begin
      seq_valid_in   = seq_valid_ff;
      current_seq_in = current_seq_ff;
      if (accept && !is_flush) begin
         seq_valid_in   = 1'b1;
         current_seq_in = req_seq_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff   <= 1'b0;
         current_seq_ff <= 32'd0;
      end else begin
         seq_valid_ff   <= seq_valid_in;
         current_seq_ff <= current_seq_in;
      end
   end

endmodule

// ===== src/mect_queue.sv =====
`timescale 1ns / 1ps
// Small register FIFO carrying commands from front to back.
module mect_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mect_pkg::entry_type        push_entry,
   input  logic                       pop,
   output mect_pkg::entry_type        head,
   output mect_pkg::queue_status_type status
);

   mect_pkg::entry_type             mem_ff [mect_pkg::QUEUE_DEPTH];
   logic [mect_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mect_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mect_pkg::QUEUE_AW:0]     count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.full  = (count_ff == (mect_pkg::QUEUE_AW+1)'(mect_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (do_push ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (do_pop ? 1'b1 : 1'b0);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/mect_back.sv =====
`timescale 1ns / 1ps
// Back end: applies commands, commits groups and emits cursor events.
module mect_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mect_pkg::cfg_type          cfg,
   input  mect_pkg::queue_status_type q_status,
   input  mect_pkg::entry_type        q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_event_code,
   output logic signed [29:0]         rsp_pos_x_out,
   output logic signed [29:0]         rsp_pos_y_out,
   output logic                       rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_EMIT   = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [31:0]        pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic               pend_left_ff, pend_left_in, pend_right_ff, pend_right_in;
   logic [31:0]        big_x_ff, big_x_in, big_y_ff, big_y_in;
   logic signed [29:0] cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic               left_down_ff, left_down_in, right_down_ff, right_down_in;
   logic [31:0]        left_press_ff, left_press_in, right_press_ff, right_press_in;
   logic signed [29:0] nx_ff, nx_in, ny_ff, ny_in;
   mect_pkg::entry_type cur_ff, cur_in;
   logic [2:0]         ev_ff, ev_in;
   logic [2:0]         left_code_ff, left_code_in, right_code_ff, right_code_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_code_ff, rsp_code_in;
   logic signed [29:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [31:0]        x_adj, y_adj;
   logic signed [29:0] qx, qy, nx_calc, ny_calc;
   logic               out_free;
   logic               move, left_chg, right_chg, left_dbl, right_dbl;
   logic [2:0]         ev_rest;
   mect_pkg::entry_type sel;
   logic               apply;
   logic [31:0]        base_x, base_y;
   logic               base_left, base_right;

   // Raise to the low bound, then lower to the high bound; the high bound wins
   function automatic logic signed [29:0] clamp_axis(input logic signed [29:0] v,
                                                     input logic [11:0] lo,
                                                     input logic [12:0] hi_excl);
      logic signed [31:0] r, lo_s, hi_s;
      r    = {{2{v[29]}}, v};
      lo_s = $signed({20'd0, lo});
      hi_s = $signed({19'd0, hi_excl}) - 32'sd1;
      if (r < lo_s) r = lo_s;
      if (r > hi_s) r = hi_s;
      return r[29:0];
   endfunction

   // Divide by four truncating toward zero
   assign x_adj = pend_x_ff + (pend_x_ff[31] ? 32'd3 : 32'd0);
   assign y_adj = pend_y_ff + (pend_y_ff[31] ? 32'd3 : 32'd0);
   assign qx    = x_adj[31:2];
   assign qy    = y_adj[31:2];
   assign nx_calc = cfg.clamp_enable ? clamp_axis(qx, cfg.clip_left, cfg.clip_right) : qx;
   assign ny_calc = cfg.clamp_enable ? clamp_axis(qy, cfg.clip_top, cfg.clip_bottom) : qy;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign move      = (nx_ff != cursor_x_ff) || (ny_ff != cursor_y_ff);
   assign left_chg  = (pend_left_ff != left_down_ff);
   assign right_chg = (pend_right_ff != right_down_ff);
   assign left_dbl  = (cur_ff.time_now - left_press_ff) <= {16'd0, cfg.double_click_time};
   assign right_dbl = (cur_ff.time_now - right_press_ff) <= {16'd0, cfg.double_click_time};
   assign ev_rest   = ev_ff & (ev_ff - 3'd1);

   assign q_pop = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in       = state_ff;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      pend_left_in   = pend_left_ff;
      pend_right_in  = pend_right_ff;
      big_x_in       = big_x_ff;
      big_y_in       = big_y_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      left_down_in   = left_down_ff;
      right_down_in  = right_down_ff;
      left_press_in  = left_press_ff;
      right_press_in = right_press_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      cur_in         = cur_ff;
      ev_in          = ev_ff;
      left_code_in   = left_code_ff;
      right_code_in  = right_code_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_code_in    = rsp_code_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_last_in    = rsp_last_ff;
      sel            = q_head;
      apply          = 1'b0;
      base_x         = pend_x_ff;
      base_y         = pend_y_ff;
      base_left      = pend_left_ff;
      base_right     = pend_right_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_head.commit) begin
                  nx_in    = nx_calc;
                  ny_in    = ny_calc;
                  cur_in   = q_head;
                  state_in = ST_UPDATE;
               end else begin
                  apply = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            sel   = cur_ff;
            apply = 1'b1;
            if (move) begin
               cursor_x_in = nx_ff;
               cursor_y_in = ny_ff;
               big_x_in    = {nx_ff, 2'b00};
               big_y_in    = {ny_ff, 2'b00};
            end
            left_down_in  = pend_left_ff;
            right_down_in = pend_right_ff;
            if (left_chg && pend_left_ff) begin
               left_press_in = left_dbl ? 32'd0 : cur_ff.time_now;
            end
            if (right_chg && pend_right_ff) begin
               right_press_in = right_dbl ? 32'd0 : cur_ff.time_now;
            end
            left_code_in  = !pend_left_ff ? mect_pkg::EV_LEFT_UP :
                            (left_dbl ? mect_pkg::EV_LEFT_DOUBLE : mect_pkg::EV_LEFT_DOWN);
            right_code_in = !pend_right_ff ? mect_pkg::EV_RIGHT_UP :
                            (right_dbl ? mect_pkg::EV_RIGHT_DOUBLE : mect_pkg::EV_RIGHT_DOWN);
            // Reload pending from the committed state
            base_x     = move ? {nx_ff, 2'b00} : big_x_ff;
            base_y     = move ? {ny_ff, 2'b00} : big_y_ff;
            base_left  = pend_left_ff;
            base_right = pend_right_ff;
            ev_in      = {right_chg, left_chg, move};
            state_in   = (move || left_chg || right_chg) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = cursor_x_ff;
               rsp_y_in     = cursor_y_ff;
               priority if (ev_ff[0]) begin
                  rsp_code_in = mect_pkg::EV_MOVE;
               end else if (ev_ff[1]) begin
                  rsp_code_in = left_code_ff;
               end else begin
                  rsp_code_in = right_code_ff;
               end
               rsp_last_in = (ev_rest == 3'd0);
               ev_in       = ev_rest;
               if (ev_rest == 3'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (apply) begin
         pend_x_in     = base_x;
         pend_y_in     = base_y;
         pend_left_in  = base_left;
         pend_right_in = base_right;
         unique case (sel.kind)
            mect_pkg::KIND_X:     pend_x_in     = base_x + sel.value;
            mect_pkg::KIND_Y:     pend_y_in     = base_y + sel.value;
            mect_pkg::KIND_LEFT:  pend_left_in  = sel.value[0];
            mect_pkg::KIND_RIGHT: pend_right_in = sel.value[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_x_ff      <= 32'd0;
         pend_y_ff      <= 32'd0;
         pend_left_ff   <= 1'b0;
         pend_right_ff  <= 1'b0;
         big_x_ff       <= 32'd0;
         big_y_ff       <= 32'd0;
         cursor_x_ff    <= 30'sd0;
         cursor_y_ff    <= 30'sd0;
         left_down_ff   <= 1'b0;
         right_down_ff  <= 1'b0;
         left_press_ff  <= 32'd0;
         right_press_ff <= 32'd0;
         ev_ff          <= 3'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_x_ff      <= pend_x_in;
         pend_y_ff      <= pend_y_in;
         pend_left_ff   <= pend_left_in;
         pend_right_ff  <= pend_right_in;
         big_x_ff       <= big_x_in;
         big_y_ff       <= big_y_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         left_down_ff   <= left_down_in;
         right_down_ff  <= right_down_in;
         left_press_ff  <= left_press_in;
         right_press_ff <= right_press_in;
         ev_ff          <= ev_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff         <= nx_in;
      ny_ff         <= ny_in;
      cur_ff        <= cur_in;
      left_code_ff  <= left_code_in;
      right_code_ff <= right_code_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_pos_x_out  = rsp_x_ff;
   assign rsp_pos_y_out  = rsp_y_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== src/mouse_event_cursor_tracker_top.sv =====
`timescale 1ns / 1ps
// Top level of the mouse event cursor tracker: config registers, front, queue, back.
// A commit passes the command queue and the back end's update and emit states before its
// events show on the registered rsp outputs. Throughput: one item per cycle into a 4-entry
// command queue unless full (req_stall); the back end pops none while in update or emit.
// Reset (synchronous, active high) clears all cursor, button and sequence state and
// loads the configuration defaults.
module mouse_event_cursor_tracker_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_op,
   input  logic signed [15:0]   req_data,
   input  logic [31:0]          req_seq_id,
   input  logic [31:0]          req_time_now,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_event_code,
   output logic signed [29:0]   rsp_pos_x_out,
   output logic signed [29:0]   rsp_pos_y_out,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [mect_pkg::CSR_DATA_W-1:0] csr_write_data
);

   mect_pkg::cfg_type          cfg_ff, cfg_in;
   mect_pkg::queue_status_type q_status;
   mect_pkg::entry_type        q_entry, q_head;
   logic                       q_push, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mect_pkg::CSR_X_SENSITIVITY:     cfg_in.x_sensitivity     = csr_write_data[7:0];
            mect_pkg::CSR_Y_SENSITIVITY:     cfg_in.y_sensitivity     = csr_write_data[7:0];
            mect_pkg::CSR_CLIP_LEFT:         cfg_in.clip_left         = csr_write_data[11:0];
            mect_pkg::CSR_CLIP_RIGHT:        cfg_in.clip_right        = csr_write_data[12:0];
            mect_pkg::CSR_CLIP_TOP:          cfg_in.clip_top          = csr_write_data[11:0];
            mect_pkg::CSR_CLIP_BOTTOM:       cfg_in.clip_bottom       = csr_write_data[12:0];
            mect_pkg::CSR_CLAMP_ENABLE:      cfg_in.clamp_enable      = csr_write_data[0];
            mect_pkg::CSR_DOUBLE_CLICK_TIME: cfg_in.double_click_time = csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_sensitivity     <= mect_pkg::RST_SENSITIVITY;
         cfg_ff.y_sensitivity     <= mect_pkg::RST_SENSITIVITY;
         cfg_ff.clip_left         <= 12'd0;
         cfg_ff.clip_right        <= mect_pkg::RST_CLIP_FAR;
         cfg_ff.clip_top          <= 12'd0;
         cfg_ff.clip_bottom       <= mect_pkg::RST_CLIP_FAR;
         cfg_ff.clamp_enable      <= 1'b0;
         cfg_ff.double_click_time <= mect_pkg::RST_DOUBLE_CLICK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mect_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_data     (req_data),
      .req_seq_id   (req_seq_id),
      .req_time_now (req_time_now),
      .cfg          (cfg_ff),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   mect_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   mect_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_code (rsp_event_code),
      .rsp_pos_x_out  (rsp_pos_x_out),
      .rsp_pos_y_out  (rsp_pos_y_out),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== src/mect_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the mouse event cursor tracker, bound to the top level.
module mect_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [2:0]           rsp_event_code,
   input logic signed [29:0]   rsp_pos_x_out,
   input logic signed [29:0]   rsp_pos_y_out,
   input logic                 rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code) && $stable(rsp_last)
         && $stable(rsp_pos_x_out) && $stable(rsp_pos_y_out))
      else $error("stalled result changed");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Events of one commit follow back to back, share a position, and a move leads
   a_commit_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid
         && (rsp_event_code != mect_pkg::EV_MOVE)
         && $stable(rsp_pos_x_out) && $stable(rsp_pos_y_out))
      else $error("commit burst broken");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code != 3'd7))
      else $error("undefined event code");

endmodule

bind mouse_event_cursor_tracker_top mect_checker u_checker (.*);

// ===== tb/mouse_event_cursor_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the mouse event cursor tracker: directed table, then random traffic.
module mouse_event_cursor_tracker_top_tb;

   // Ops that the block treats like an ignored element
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;
   localparam int DRILL_ROWS = 25;

   typedef struct packed {
      logic [2:0]  code;
      logic [29:0] x;
      logic [29:0] y;
      logic        last;
   } cursor_event_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] data;
      logic [31:0] seq;
      logic [31:0] stamp;
      logic        fixed;      // expectation typed in below instead of predicted
      logic        has_event;  // fixed row that commits exactly one event
      logic [2:0]  code;
      logic [29:0] x;
      logic [29:0] y;
   } drill_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [2:0]                    req_op;
   logic signed [15:0]            req_data;
   logic [31:0]                   req_seq_id;
   logic [31:0]                   req_time_now;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [2:0]                    rsp_event_code;
   logic signed [29:0]            rsp_pos_x_out;
   logic signed [29:0]            rsp_pos_y_out;
   logic                          rsp_last;
   logic                          csr_write_enable;
   logic [2:0]                    csr_index;
   logic [mect_pkg::CSR_DATA_W-1:0] csr_write_data;

   // Tracker copy kept by the testbench
   mect_pkg::cfg_type cfg;
   logic [31:0] pend_qx, pend_qy, qx, qy;
   bit          pend_l, pend_r, l_down, r_down;
   longint      cur_x, cur_y;
   logic [31:0] l_press, r_press, open_seq;
   bit          seq_open;

   cursor_event_type fresh_events[$];
   cursor_event_type expected_events[$];
   drill_row_type    drill_table [DRILL_ROWS];

   int          fail_count = 0;
   int          items_accepted = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [31:0] now_ms = 32'd0;
   logic [31:0] seq_ctr = 32'd100;

   mouse_event_cursor_tracker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data         (req_data),
      .req_seq_id       (req_seq_id),
      .req_time_now     (req_time_now),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_pos_x_out    (rsp_pos_x_out),
      .rsp_pos_y_out    (rsp_pos_y_out),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < stall_pct);
   end

   task automatic push_cursor_event(input logic [2:0] code);
      fresh_events.push_back('{code, cur_x[29:0], cur_y[29:0], 1'b0});
   endtask

   task automatic update_button(inout bit down, input bit pend, inout logic [31:0] press_t,
                                input logic [31:0] now, input logic [2:0] down_code,
                                input logic [2:0] double_code, input logic [2:0] up_code);
      logic [31:0] gap;
      if (down != pend) begin
         down = pend;
         if (pend) begin
            gap = now - press_t;
            if (gap <= 32'(cfg.double_click_time)) begin
               push_cursor_event(double_code);
               press_t = 32'd0;
            end else begin
               push_cursor_event(down_code);
               press_t = now;
            end
         end else begin
            push_cursor_event(up_code);
         end
      end
   endtask

   task automatic commit_cursor(input logic [31:0] now);
      longint           nx;
      longint           ny;
      int               start;
      cursor_event_type tail;
      start = fresh_events.size();
      // quarter pixels to pixels, truncating toward zero
      nx = longint'($signed(pend_qx)) / 4;
      ny = longint'($signed(pend_qy)) / 4;
      if (cfg.clamp_enable) begin
         if (nx < longint'(cfg.clip_left)) nx = longint'(cfg.clip_left);
         if (nx > longint'(cfg.clip_right) - 1) nx = longint'(cfg.clip_right) - 1;
         if (ny < longint'(cfg.clip_top)) ny = longint'(cfg.clip_top);
         if (ny > longint'(cfg.clip_bottom) - 1) ny = longint'(cfg.clip_bottom) - 1;
      end
      if (nx != cur_x || ny != cur_y) begin
         cur_x = nx;
         cur_y = ny;
         qx = 32'(nx * 4);
         qy = 32'(ny * 4);
         push_cursor_event(mect_pkg::EV_MOVE);
      end
      update_button(l_down, pend_l, l_press, now, mect_pkg::EV_LEFT_DOWN,
                    mect_pkg::EV_LEFT_DOUBLE, mect_pkg::EV_LEFT_UP);
      update_button(r_down, pend_r, r_press, now, mect_pkg::EV_RIGHT_DOWN,
                    mect_pkg::EV_RIGHT_DOUBLE, mect_pkg::EV_RIGHT_UP);
      if (fresh_events.size() > start) begin
         tail = fresh_events.pop_back();
         tail.last = 1'b1;
         fresh_events.push_back(tail);
      end
      pend_qx = qx;
      pend_qy = qy;
      pend_l = l_down;
      pend_r = r_down;
   endtask

   task automatic track_element(input logic [2:0] op, input logic [15:0] data,
                                input logic [31:0] seq, input logic [31:0] now);
      logic [31:0] delta;
      delta = {{16{data[15]}}, data};
      fresh_events.delete();
      if (op == mect_pkg::OP_FLUSH) begin
         commit_cursor(now);
      end else begin
         if (!seq_open) begin
            open_seq = seq;
            seq_open = 1'b1;
         end else if (seq != open_seq) begin
            commit_cursor(now);
            open_seq = seq;
         end
         case (op)
            mect_pkg::OP_X_DELTA: pend_qx = pend_qx + 32'(cfg.x_sensitivity) * delta;
            mect_pkg::OP_Y_DELTA: pend_qy = pend_qy + 32'(cfg.y_sensitivity) * delta;
            mect_pkg::OP_LEFT:    pend_l = (data[7:0] != 8'd0);
            mect_pkg::OP_RIGHT:   pend_r = (data[7:0] != 8'd0);
            default: ;
         endcase
      end
   endtask

   task automatic send_element(input logic [2:0] op, input logic [15:0] data,
                               input logic [31:0] seq, input logic [31:0] now,
                               input bit fixed);
      bit done;
      case ((items_accepted / 25) % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 77; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 77; end
         default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_data = data;
      req_seq_id = seq;
      req_time_now = now;
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         if (!req_stall) done = 1'b1;
         else @(negedge clock);
      end
      track_element(op, data, seq, now);
      if (!fixed) begin
         foreach (fresh_events[i]) expected_events.push_back(fresh_events[i]);
      end
      items_accepted++;
   endtask

   task automatic wait_for_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      // items that commit nothing may still sit in the command queue
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input mect_pkg::cfg_type s);
      logic [15:0] vals [8];
      vals[mect_pkg::CSR_X_SENSITIVITY]     = 16'(s.x_sensitivity);
      vals[mect_pkg::CSR_Y_SENSITIVITY]     = 16'(s.y_sensitivity);
      vals[mect_pkg::CSR_CLIP_LEFT]         = 16'(s.clip_left);
      vals[mect_pkg::CSR_CLIP_RIGHT]        = 16'(s.clip_right);
      vals[mect_pkg::CSR_CLIP_TOP]          = 16'(s.clip_top);
      vals[mect_pkg::CSR_CLIP_BOTTOM]       = 16'(s.clip_bottom);
      vals[mect_pkg::CSR_CLAMP_ENABLE]      = 16'(s.clamp_enable);
      vals[mect_pkg::CSR_DOUBLE_CLICK_TIME] = s.double_click_time;
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_write_enable = 1'b1;
         csr_index = 3'(i);
         csr_write_data = vals[i];
      end
      @(negedge clock);
      csr_write_enable = 1'b0;
      cfg = s;
   endtask

   task automatic random_traffic(input int count, input bit drift);
      int          sent;
      int          grp_len;
      int          pick;
      logic [2:0]  op;
      logic [15:0] data;
      logic [31:0] seq;
      logic [31:0] stamp;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(19);
         if (pick < 15) seq_ctr = seq_ctr + 32'd1;
         else if (pick < 17) seq_ctr = $urandom;
         else if (pick == 17) seq_ctr = 32'd0;
         else if (pick == 18) seq_ctr = 32'hFFFF_FFFF;
         pick = $urandom_range(19);
         if (pick < 15) now_ms = now_ms + 32'($urandom_range(1, 400));
         else if (pick < 18) now_ms = $urandom;
         else if (pick == 18) now_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 200));
         grp_len = $urandom_range(1, 4);
         for (int k = 0; k < grp_len; k++) begin
            seq = seq_ctr;
            stamp = now_ms;
            if (drift && $urandom_range(99) < 95) begin
               // push the accumulator toward wrap-around
               op = mect_pkg::OP_X_DELTA;
               data = 16'h7FFF;
            end else begin
               pick = $urandom_range(99);
               if (pick < 25) op = drift ? mect_pkg::OP_Y_DELTA : mect_pkg::OP_X_DELTA;
               else if (pick < 50) op = mect_pkg::OP_Y_DELTA;
               else if (pick < 63) op = mect_pkg::OP_LEFT;
               else if (pick < 76) op = mect_pkg::OP_RIGHT;
               else if (pick < 82) op = mect_pkg::OP_IGNORE;
               else if (pick < 86) op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
               else op = mect_pkg::OP_FLUSH;
               pick = $urandom_range(9);
               if (op == mect_pkg::OP_X_DELTA || op == mect_pkg::OP_Y_DELTA) begin
                  if (pick < 6) data = 16'($urandom_range(0, 128)) - 16'd64;
                  else if (pick < 8) data = 16'($urandom);
                  else if (pick == 8) data = 16'h7FFF;
                  else data = 16'h8000;
               end else if (pick < 5) begin
                  data = {8'($urandom), 8'h00};
               end else begin
                  data = 16'($urandom);
               end
               if ($urandom_range(99) < 6) begin
                  op = 3'($urandom);
                  data = 16'($urandom);
                  seq = $urandom;
                  stamp = $urandom;
               end
            end
            send_element(op, data, seq, stamp, 1'b0);
            sent++;
         end
         if ($urandom_range(4) == 0) begin
            send_element(mect_pkg::OP_FLUSH, 16'($urandom), $urandom, now_ms, 1'b0);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      cursor_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected event: code %0d x %0d y %0d last %0d",
                        rsp_event_code, rsp_pos_x_out, rsp_pos_y_out, rsp_last);
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_code !== want.code || rsp_pos_x_out !== want.x ||
                rsp_pos_y_out !== want.y || rsp_last !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"event mismatch: expected code %0d x %0d y %0d last %0d,",
                            " got %0d %0d %0d %0d"},
                           want.code, $signed(want.x), $signed(want.y), want.last,
                           rsp_event_code, rsp_pos_x_out, rsp_pos_y_out, rsp_last);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      drill_row_type     row;
      mect_pkg::cfg_type s;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = mect_pkg::OP_IGNORE;
      req_data = '0;
      req_seq_id = '0;
      req_time_now = '0;
      csr_write_enable = 1'b0;
      csr_index = mect_pkg::CSR_X_SENSITIVITY;
      csr_write_data = '0;
      cfg = '{x_sensitivity: mect_pkg::RST_SENSITIVITY,
              y_sensitivity: mect_pkg::RST_SENSITIVITY,
              clip_left: 12'd0, clip_right: mect_pkg::RST_CLIP_FAR, clip_top: 12'd0,
              clip_bottom: mect_pkg::RST_CLIP_FAR, clamp_enable: 1'b0,
              double_click_time: mect_pkg::RST_DOUBLE_CLICK};
      pend_qx = '0; pend_qy = '0; qx = '0; qy = '0;
      pend_l = 1'b0; pend_r = 1'b0; l_down = 1'b0; r_down = 1'b0;
      cur_x = 0; cur_y = 0;
      l_press = '0; r_press = '0; open_seq = '0; seq_open = 1'b0;

      // op, data, seq, time, fixed, has_event, code, x, y
      drill_table = '{
         '{mect_pkg::OP_X_DELTA, 16'd8, 32'd1, 32'd10, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_Y_DELTA, -16'sd4, 32'd1, 32'd10, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, '1, 32'd20, 1'b1, 1'b1,
           mect_pkg::EV_MOVE, 30'd2, -30'sd1},
         '{mect_pkg::OP_LEFT, 16'h0100, 32'd1, 32'd25, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, 32'd1, 32'd30, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_LEFT, 16'h0001, 32'd2, 32'd100, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, 32'd2, 32'd100, 1'b1, 1'b1,
           mect_pkg::EV_LEFT_DOUBLE, 30'd2, -30'sd1},
         '{mect_pkg::OP_LEFT, 16'hFF00, 32'd3, 32'd2000, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_RIGHT, 16'h8080, 32'd3, 32'd2000, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_X_DELTA, 16'd3, 32'd3, 32'd2000, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, 32'd3, 32'd2000, 1'b0, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_X_DELTA, 16'd1, 32'd4, 32'd2100, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, 32'd4, 32'd2100, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_X_DELTA, 16'h8000, 32'd5, 32'd2150, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_Y_DELTA, 16'h7FFF, 32'd5, 32'd2150, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_RIGHT, 16'h0000, 32'd5, 32'd2150, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_IGNORE, 16'h7FFF, 32'd6, 32'd2150, 1'b0, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{OP_SPARE_LO, 16'h5555, 32'd6, 32'd2155, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{OP_SPARE_HI, 16'hAAAA, 32'd7, 32'd2160, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_X_DELTA, -16'sd3, 32'd8, 32'd2165, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, 32'd8, 32'd2170, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_RIGHT, 16'h0001, '1, 32'd2200, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'd0, '1, 32'd2200, 1'b1, 1'b1,
           mect_pkg::EV_RIGHT_DOUBLE, -30'sd8190, 30'd8190},
         '{mect_pkg::OP_LEFT, 16'h00FF, 32'd0, '1, 1'b1, 1'b0,
           mect_pkg::EV_MOVE, 30'd0, 30'd0},
         '{mect_pkg::OP_FLUSH, 16'hFFFF, 32'd0, '1, 1'b1, 1'b1,
           mect_pkg::EV_LEFT_DOWN, -30'sd8190, 30'd8190}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (drill_table[i]) begin
         row = drill_table[i];
         send_element(row.op, row.data, row.seq, row.stamp, row.fixed);
         if (row.fixed && row.has_event)
            expected_events.push_back('{row.code, row.x, row.y, 1'b1});
      end
      now_ms = 32'd3000;
      wait_for_quiet();

      // full-screen clamp, strongest scaling, doubles only at equal times
      apply_settings('{x_sensitivity: 8'd255, y_sensitivity: 8'd255, clip_left: 12'd0,
                       clip_right: 13'd4096, clip_top: 12'd0, clip_bottom: 13'd4096,
                       clamp_enable: 1'b1, double_click_time: 16'd0});
      random_traffic(60, 1'b0);
      wait_for_quiet();

      // x box inverted, y box one pixel high, widest double-click window
      apply_settings('{x_sensitivity: 8'd1, y_sensitivity: 8'd2, clip_left: 12'd4095,
                       clip_right: 13'd1, clip_top: 12'd4095, clip_bottom: 13'd4096,
                       clamp_enable: 1'b1, double_click_time: 16'hFFFF});
      random_traffic(40, 1'b0);
      wait_for_quiet();

      s.x_sensitivity = 8'($urandom_range(1, 255));
      s.y_sensitivity = 8'($urandom_range(1, 255));
      s.clip_left = 12'($urandom_range(0, 4095));
      s.clip_right = 13'($urandom_range(1, 4096));
      s.clip_top = 12'd0;
      s.clip_bottom = 13'd1;
      s.clamp_enable = 1'b1;
      s.double_click_time = 16'($urandom_range(0, 600));
      apply_settings(s);
      random_traffic(40, 1'b0);
      wait_for_quiet();

      // unclamped drift that pushes the quarter-pixel accumulator toward wrap-around
      s = '{x_sensitivity: 8'd255, y_sensitivity: 8'd0, clip_left: 12'd0,
            clip_right: 13'd4096, clip_top: 12'd0, clip_bottom: 13'd4096,
            clamp_enable: 1'b0, double_click_time: mect_pkg::RST_DOUBLE_CLICK};
      s.y_sensitivity = 8'($urandom_range(1, 255));
      apply_settings(s);
      random_traffic(245, 1'b1);
      wait_for_quiet();

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mect_pkg.sv
src/mect_front.sv
src/mect_queue.sv
src/mect_back.sv
src/mouse_event_cursor_tracker_top.sv
src/mect_checker.sv
tb/mouse_event_cursor_tracker_top_tb.sv
